// File: sv/kole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kole_pkg
// Types and constants shared by the ordered list engine and its cells.
// ----------------------------------------------------------------------------
package kole_pkg;

   localparam int DEPTH       = 32;
   localparam int MAX_RESULTS = 32;
   localparam int LIST_MAX    = (MAX_RESULTS < DEPTH) ? MAX_RESULTS : DEPTH;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      KIND_INS_FRONT  = 4'd0,
      KIND_INS_END    = 4'd1,
      KIND_INS_AFTER  = 4'd2,
      KIND_INS_BEFORE = 4'd3,
      KIND_RM_FRONT   = 4'd4,
      KIND_RM_END     = 4'd5,
      KIND_RM_ID      = 4'd6,
      KIND_SEARCH     = 4'd7,
      KIND_LIST       = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT,
      CELL_FROM_HEAD
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_APPLY,
      S_LIST
   } state_type;

   typedef struct packed {
      logic signed [31:0] id;
      logic signed [31:0] phone;
   } entry_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [31:0] item_id;
      logic signed [31:0] item_phone;
      logic signed [31:0] ref_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_id;
      logic signed [31:0] out_phone;
      logic [5:0]         entry_count;
      logic               last;
   } rsp_type;

endpackage

// File: sv/kole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kole_cell
// One list position: holds an entry, compares its id against the key and
// takes a new value from the request, a neighbor or the head of the row.
// ----------------------------------------------------------------------------
module kole_cell (
   input  logic                   clock,
   input  kole_pkg::cell_cmd_type cmd,
   input  logic signed [31:0]     key,
   input  kole_pkg::entry_type    new_data,
   input  kole_pkg::entry_type    left_data,
   input  kole_pkg::entry_type    right_data,
   input  kole_pkg::entry_type    head_data,
   output kole_pkg::entry_type    data,
   output logic                   hit
);
   import kole_pkg::*;

   entry_type data_ff, data_in;
   logic      hit_ff, hit_in;

   always_comb begin
      hit_in = (data_ff.id == key);
      case (cmd)
         CELL_LOAD:       data_in = new_data;
         CELL_FROM_LEFT:  data_in = left_data;
         CELL_FROM_RIGHT: data_in = right_data;
         CELL_FROM_HEAD:  data_in = head_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// File: sv/keyed_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_ordered_list_engine
// Ordered list of up to DEPTH id/phone entries held in a row of cells.
// ----------------------------------------------------------------------------
// Every operation has a request transfer cycle, at whose edge each cell
// compares its id with ref_id, and an apply cycle, in which the first match
// is picked, the cells from the insert or remove point on shift by one place
// at once, and the result register is written; the result is offered from the
// next cycle. A new request is taken once the previous operation has written
// its result register, even while that result still waits, so a waiting result
// stalls only the apply cycle of the following request. List rotates the row
// one place per cycle through its head cell, stalling while an entry waits on
// the result side, and the row is back in order when it finishes.
module keyed_ordered_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kole_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kole_pkg::rsp_type rsp_data
);
   import kole_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] list_idx_ff, list_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   req_type          req_ff, req_in;

   entry_type        cell_q [DEPTH];
   cell_cmd_type     cmd [DEPTH];
   logic [DEPTH-1:0] hit, hitv, le, fm;
   entry_type        new_entry, found_entry;

   logic             slot_free, list_go, do_ins, do_rm, found, is_full;
   logic             list_emit;
   logic [CNT_W-1:0] list_n, count_m1;
   status_type       status_v;

   assign new_entry = '{id: req_ff.item_id, phone: req_ff.item_phone};
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign count_m1  = count_ff - CNT_W'(1);
   assign list_n    = (count_ff < CNT_W'(LIST_MAX)) ? count_ff : CNT_W'(LIST_MAX);
   assign list_emit = (list_idx_ff < list_n);
   assign found     = |hitv;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic prev_fm, le_m1, le_m2;
         assign hitv[i] = hit[i] && (CNT_W'(i) < count_ff);
         assign le[i]   = |hitv[i:0];
         if (i == 0) begin : g_first
            assign fm[i]   = hitv[i];
            assign prev_fm = 1'b0;
            assign le_m1   = 1'b0;
         end else begin : g_rest
            assign fm[i]   = hitv[i] && !le[i-1];
            assign prev_fm = fm[i-1];
            assign le_m1   = le[i-1];
         end
         if (i < 2) begin : g_low
            assign le_m2 = 1'b0;
         end else begin : g_high
            assign le_m2 = le[i-2];
         end

         always_comb begin
            cmd[i] = CELL_HOLD;
            if (list_go) begin
               if (CNT_W'(i) == count_m1) begin
                  cmd[i] = CELL_FROM_HEAD;
               end else if (CNT_W'(i) < count_m1) begin
                  cmd[i] = CELL_FROM_RIGHT;
               end
            end else if (do_ins) begin
               case (req_ff.kind)
                  KIND_INS_FRONT: begin
                     cmd[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                  end
                  KIND_INS_END: begin
                     if (CNT_W'(i) == count_ff) cmd[i] = CELL_LOAD;
                  end
                  KIND_INS_AFTER: begin
                     if (prev_fm) cmd[i] = CELL_LOAD;
                     else if (le_m2) cmd[i] = CELL_FROM_LEFT;
                  end
                  KIND_INS_BEFORE: begin
                     if (fm[i]) cmd[i] = CELL_LOAD;
                     else if (le_m1) cmd[i] = CELL_FROM_LEFT;
                  end
                  default: cmd[i] = CELL_HOLD;
               endcase
            end else if (do_rm) begin
               case (req_ff.kind)
                  KIND_RM_FRONT: cmd[i] = CELL_FROM_RIGHT;
                  KIND_RM_ID:    cmd[i] = le[i] ? CELL_FROM_RIGHT : CELL_HOLD;
                  default:       cmd[i] = CELL_HOLD;
               endcase
            end
         end

         kole_cell u_cell (
            .clock      (clock),
            .cmd        (cmd[i]),
            .key        (req_in.ref_id),
            .new_data   (new_entry),
            .left_data  (cell_q[(i == 0) ? 0 : i - 1]),
            .right_data (cell_q[(i == DEPTH - 1) ? i : i + 1]),
            .head_data  (cell_q[0]),
            .data       (cell_q[i]),
            .hit        (hit[i])
         );
      end
   endgenerate

   // matched entry for search
   always_comb begin
      found_entry = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (fm[k]) found_entry = found_entry | cell_q[k];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      list_idx_in  = list_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      list_go      = 1'b0;
      do_ins       = 1'b0;
      do_rm        = 1'b0;
      status_v     = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (slot_free) begin
               case (req_ff.kind)
                  KIND_INS_FRONT, KIND_INS_END: begin
                     if (is_full) status_v = STAT_FULL;
                     else do_ins = 1'b1;
                  end
                  KIND_INS_AFTER, KIND_INS_BEFORE: begin
                     if (!found) status_v = STAT_NOT_FOUND;
                     else if (is_full) status_v = STAT_FULL;
                     else do_ins = 1'b1;
                  end
                  KIND_RM_FRONT, KIND_RM_END: begin
                     if (count_ff == '0) status_v = STAT_EMPTY;
                     else do_rm = 1'b1;
                  end
                  KIND_RM_ID: begin
                     if (!found) status_v = STAT_NOT_FOUND;
                     else do_rm = 1'b1;
                  end
                  KIND_SEARCH: begin
                     if (!found) status_v = STAT_NOT_FOUND;
                  end
                  KIND_LIST: begin
                     if (count_ff == '0) status_v = STAT_EMPTY;
                  end
                  default: status_v = STAT_OK;
               endcase
               if (do_ins) count_in = count_ff + CNT_W'(1);
               if (do_rm) count_in = count_m1;
               if (req_ff.kind == KIND_LIST && count_ff != '0) begin
                  list_idx_in = '0;
                  state_in    = S_LIST;
               end else begin
                  rsp_in.status      = status_v;
                  rsp_in.out_id      = '0;
                  rsp_in.out_phone   = '0;
                  if (req_ff.kind == KIND_SEARCH && found) begin
                     rsp_in.out_id    = found_entry.id;
                     rsp_in.out_phone = found_entry.phone;
                  end
                  rsp_in.entry_count = 6'(count_in);
                  rsp_in.last        = 1'b1;
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
               end
            end
         end
         S_LIST: begin
            if (!list_emit || slot_free) begin
               list_go = 1'b1;
               if (list_emit) begin
                  rsp_in.status      = STAT_OK;
                  rsp_in.out_id      = cell_q[0].id;
                  rsp_in.out_phone   = cell_q[0].phone;
                  rsp_in.entry_count = 6'(count_ff);
                  rsp_in.last        = (list_idx_ff == list_n - CNT_W'(1));
                  rsp_valid_in       = 1'b1;
               end
               list_idx_in = list_idx_ff + CNT_W'(1);
               if (list_idx_ff == count_m1) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      req_ff <= req_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_first_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(fm))
      else $error("more than one first match");

   a_list_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST |=> count_ff == $past(count_ff))
      else $error("count changed during list");

   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_APPLY)
      else $error("transfer not followed by apply");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result overwritten");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives keyed_ordered_list_engine with a short table of directed operations
// and then fill, drain and mixed random sequences. A shadow copy of the list
// predicts the untyped results, and all are compared field by field in order.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the engine backs up into its request channel.
// ----------------------------------------------------------------------------
module testbench;
   import kole_pkg::*;

   localparam logic signed [31:0] ID_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] ID_MIN = 32'sh80000000;
   localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
   localparam logic [3:0] KIND_UNUSED_HI = 4'd15;
   localparam int RANDOM_ITEMS   = 230;
   localparam int POOL_SIZE      = 8;
   localparam int HOLD_AFTER     = 80;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_PRINTS     = 40;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} walk_type;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic    req_typed;
   rsp_type req_want;

   entry_type list_rows[DEPTH];
   int        held;
   rsp_type   step_rsps[$];
   rsp_type   pending_rsps[$];
   rsp_type   want_rsp;

   dir_row_type directed_rows[$];
   logic signed [31:0] id_pool[POOL_SIZE];

   logic req_took;
   logic rsp_took;
   int   idle_cycles;
   int   rsp_seen;
   int   errors;
   int   burst_left;
   int   sent;
   int   extra_left;
   walk_type walk_phase;

   logic held_off;
   int   ready_mode;
   int   mode_left;
   int   beat;
   logic ready_now;

   keyed_ordered_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) begin
         $display("mismatch at result %0d: %s", rsp_seen, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   // shadow list

   function automatic int find_first(input logic signed [31:0] key);
      for (int i = 0; i < held; i++) begin
         if (list_rows[i].id == key) return i;
      end
      return held;
   endfunction

   task automatic open_slot(input int pos, input entry_type e);
      for (int j = held; j > pos; j--) list_rows[j] = list_rows[j - 1];
      list_rows[pos] = e;
      held++;
   endtask

   task automatic close_slot(input int pos);
      for (int j = pos; j + 1 < held; j++) list_rows[j] = list_rows[j + 1];
      held--;
   endtask

   function automatic rsp_type make_rsp(input status_type st, input entry_type e,
                                        input logic last);
      rsp_type m;
      m.status      = st;
      m.out_id      = e.id;
      m.out_phone   = e.phone;
      m.entry_count = 6'(held);
      m.last        = last;
      return m;
   endfunction

   task automatic predict_step(input req_type r);
      int         pos;
      int         n;
      status_type st;
      entry_type  hit;
      entry_type  fresh;
      step_rsps.delete();
      st = STAT_OK;
      hit = '0;
      fresh.id = r.item_id;
      fresh.phone = r.item_phone;
      case (r.kind)
         KIND_INS_FRONT, KIND_INS_END: begin
            if (held == DEPTH) st = STAT_FULL;
            else open_slot((r.kind == KIND_INS_FRONT) ? 0 : held, fresh);
         end
         KIND_INS_AFTER, KIND_INS_BEFORE: begin
            pos = find_first(r.ref_id);
            if (pos == held) st = STAT_NOT_FOUND;
            else if (held == DEPTH) st = STAT_FULL;
            else open_slot((r.kind == KIND_INS_AFTER) ? pos + 1 : pos, fresh);
         end
         KIND_RM_FRONT, KIND_RM_END: begin
            if (held == 0) st = STAT_EMPTY;
            else close_slot((r.kind == KIND_RM_FRONT) ? 0 : held - 1);
         end
         KIND_RM_ID: begin
            pos = find_first(r.ref_id);
            if (pos == held) st = STAT_NOT_FOUND;
            else close_slot(pos);
         end
         KIND_SEARCH: begin
            pos = find_first(r.ref_id);
            if (pos == held) st = STAT_NOT_FOUND;
            else hit = list_rows[pos];
         end
         KIND_LIST: begin
            if (held == 0) begin
               st = STAT_EMPTY;
            end else begin
               n = (held < MAX_RESULTS) ? held : MAX_RESULTS;
               for (int k = 0; k < n; k++) begin
                  step_rsps.push_back(make_rsp(STAT_OK, list_rows[k], k == n - 1));
               end
               return;
            end
         end
         default: ;
      endcase
      step_rsps.push_back(make_rsp(st, hit, 1'b1));
   endtask

   // stimulus

   function automatic dir_row_type step_row(input logic [3:0] kind,
                                            input logic signed [31:0] item_id,
                                            input logic signed [31:0] item_phone,
                                            input logic signed [31:0] ref_id);
      dir_row_type d;
      d.req.kind       = kind;
      d.req.item_id    = item_id;
      d.req.item_phone = item_phone;
      d.req.ref_id     = ref_id;
      d.typed          = 1'b0;
      d.want           = '0;
      return d;
   endfunction

   function automatic dir_row_type typed_row(input logic [3:0] kind,
                                             input logic signed [31:0] item_id,
                                             input logic signed [31:0] item_phone,
                                             input logic signed [31:0] ref_id,
                                             input status_type st,
                                             input logic signed [31:0] out_id,
                                             input logic signed [31:0] out_phone,
                                             input int count);
      dir_row_type d;
      d = step_row(kind, item_id, item_phone, ref_id);
      d.typed            = 1'b1;
      d.want.status      = st;
      d.want.out_id      = out_id;
      d.want.out_phone   = out_phone;
      d.want.entry_count = 6'(count);
      d.want.last        = 1'b1;
      return d;
   endfunction

   function automatic logic signed [31:0] pick_ref();
      int roll;
      roll = $urandom_range(0, 9);
      if (held > 0 && roll < 7) return list_rows[$urandom_range(0, held - 1)].id;
      if (roll < 9) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic req_type next_random_req();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.item_id = ($urandom_range(0, 9) < 6) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : $urandom;
      r.item_phone = $urandom;
      r.ref_id = pick_ref();
      r.kind = KIND_SEARCH;
      case (walk_phase)
         PH_FILL: begin
            if (held == DEPTH) begin
               r.kind = 4'($urandom_range(KIND_INS_FRONT, KIND_INS_BEFORE));
               if (roll < 50) r.ref_id = $urandom;
               extra_left--;
            end else if (roll < 80) begin
               r.kind = 4'($urandom_range(KIND_INS_FRONT, KIND_INS_BEFORE));
            end else if (roll < 88) begin
               r.kind = KIND_SEARCH;
            end else if (roll < 92) begin
               r.kind = KIND_LIST;
            end else if (roll < 97) begin
               r.kind = 4'($urandom_range(KIND_RM_FRONT, KIND_RM_ID));
            end else begin
               r.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            end
         end
         PH_DRAIN: begin
            if (held == 0) begin
               r.kind = 4'($urandom_range(KIND_INS_AFTER, KIND_LIST));
               extra_left--;
            end else if (roll < 70) begin
               r.kind = 4'($urandom_range(KIND_RM_FRONT, KIND_RM_ID));
            end else if (roll < 80) begin
               r.kind = KIND_SEARCH;
            end else if (roll < 85) begin
               r.kind = KIND_LIST;
            end else if (roll < 97) begin
               r.kind = 4'($urandom_range(KIND_INS_FRONT, KIND_INS_BEFORE));
            end else begin
               r.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            end
         end
         default: begin
            if (roll < 94) r.kind = 4'($urandom_range(KIND_INS_FRONT, KIND_LIST));
            else r.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         end
      endcase
      return r;
   endfunction

   task automatic send_paced(input req_type r, input logic typed, input rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      req_typed <= typed;
      req_want  <= want;
      do @(negedge clock); while (!req_took);
   endtask

   // monitor, checker and watchdog

   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
         rsp_took = 1'b0;
         idle_cycles = 0;
      end else begin
         rsp_took = rsp_valid && rsp_ready;
         req_took = req_valid && req_ready;
         if (rsp_took) begin
            if (pending_rsps.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: %h", rsp_data));
            end else begin
               want_rsp = pending_rsps.pop_front();
               check_field("status", 32'(rsp_data.status), 32'(want_rsp.status));
               check_field("out_id", rsp_data.out_id, want_rsp.out_id);
               check_field("out_phone", rsp_data.out_phone, want_rsp.out_phone);
               check_field("entry_count", 32'(rsp_data.entry_count),
                           32'(want_rsp.entry_count));
               check_field("last", 32'(rsp_data.last), 32'(want_rsp.last));
            end
            rsp_seen++;
         end
         if (req_took) begin
            predict_step(req_data);
            if (req_typed) begin
               pending_rsps.push_back(req_want);
            end else begin
               foreach (step_rsps[k]) pending_rsps.push_back(step_rsps[k]);
            end
         end
         idle_cycles = (req_took || rsp_took) ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // result side stalls, with one long hold-off

   initial begin
      rsp_ready = 1'b0;
      held_off = 1'b0;
      mode_left = 0;
      beat = 0;
      forever begin
         @(negedge clock);
         if (!held_off && rsp_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         beat++;
         case (ready_mode)
            0: ready_now = 1'b1;
            1: ready_now = $urandom_range(0, 1);
            2: ready_now = ($urandom_range(0, 3) == 0);
            default: ready_now = (beat % 3 != 0);
         endcase
         rsp_ready <= ready_now;
      end
   end

   // main sequence

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      req_typed = 1'b0;
      req_want = '0;
      held = 0;
      errors = 0;
      rsp_seen = 0;
      burst_left = 0;
      sent = 0;
      req_took = 1'b0;
      rsp_took = 1'b0;
      idle_cycles = 0;
      foreach (list_rows[i]) list_rows[i] = '0;

      id_pool[0] = 32'sd0;
      id_pool[1] = -32'sd1;
      id_pool[2] = ID_MAX;
      id_pool[3] = ID_MIN;
      for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = $urandom;

      // empty list first, then extremes, duplicates and first-match lookups
      directed_rows.push_back(typed_row(KIND_LIST, 0, 0, 0, STAT_EMPTY, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_RM_FRONT, 0, 0, 0, STAT_EMPTY, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_RM_END, 0, 0, 0, STAT_EMPTY, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_RM_ID, 0, 0, 5, STAT_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_SEARCH, 0, 0, 0, STAT_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_INS_AFTER, 1, 1, 0, STAT_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_INS_BEFORE, 1, 1, -1, STAT_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_UNUSED_HI, ID_MAX, ID_MIN, -1, STAT_OK, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_INS_FRONT, ID_MAX, ID_MIN, 0, STAT_OK, 0, 0, 1));
      directed_rows.push_back(typed_row(KIND_INS_END, ID_MIN, ID_MAX, 0, STAT_OK, 0, 0, 2));
      directed_rows.push_back(typed_row(KIND_SEARCH, 0, 0, ID_MIN, STAT_OK,
                                        ID_MIN, ID_MAX, 2));
      directed_rows.push_back(step_row(KIND_INS_AFTER, -1, 0, ID_MAX));
      directed_rows.push_back(step_row(KIND_INS_BEFORE, 0, -1, ID_MIN));
      directed_rows.push_back(step_row(KIND_INS_END, -1, 32'sh5a5a5a5a, 0));
      directed_rows.push_back(step_row(KIND_SEARCH, 0, 0, -1));
      directed_rows.push_back(step_row(KIND_LIST, 0, 0, 0));
      directed_rows.push_back(step_row(KIND_RM_ID, 0, 0, -1));
      directed_rows.push_back(typed_row(KIND_INS_BEFORE, 3, 3, 32'sh12345,
                                        STAT_NOT_FOUND, 0, 0, 4));
      directed_rows.push_back(step_row(KIND_UNUSED_LO, 0, 0, 0));
      directed_rows.push_back(step_row(KIND_RM_FRONT, 0, 0, 0));
      directed_rows.push_back(step_row(KIND_RM_END, 0, 0, 0));
      directed_rows.push_back(step_row(KIND_RM_ID, 0, 0, ID_MIN));
      directed_rows.push_back(step_row(KIND_RM_END, 0, 0, 0));
      directed_rows.push_back(typed_row(KIND_LIST, 0, 0, 0, STAT_EMPTY, 0, 0, 0));

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_paced(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      // fill to full, drain to empty, mix, and around again
      walk_phase = PH_FILL;
      extra_left = $urandom_range(4, 8);
      while (sent < RANDOM_ITEMS) begin
         req_type r;
         r = next_random_req();
         if (r.kind <= KIND_LIST) sent++;
         send_paced(r, 1'b0, '0);
         case (walk_phase)
            PH_FILL: begin
               if (extra_left <= 0) begin
                  walk_phase = PH_DRAIN;
                  extra_left = $urandom_range(2, 6);
               end
            end
            PH_DRAIN: begin
               if (extra_left <= 0) begin
                  walk_phase = PH_MIX;
                  extra_left = $urandom_range(20, 40);
               end
            end
            default: begin
               extra_left--;
               if (extra_left <= 0) begin
                  walk_phase = PH_FILL;
                  extra_left = $urandom_range(4, 8);
               end
            end
         endcase
      end
      req_valid <= 1'b0;

      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
